// ===== rtl/core/rne_pkg.sv =====
`timescale 1ns / 1ps

package rne_pkg;

    // Field widths
    localparam int NUM_W    = 13;
    localparam int VAL_W    = 12;
    localparam int LETTER_W = 8;

    // Greedy table
    localparam int TABLE_LEN = 13;
    localparam int IDX_W     = 4;

    // Largest value that still has a numeral is one below this
    localparam logic [VAL_W-1:0] RN_LIMIT = 12'd4000;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [VAL_W-1:0]    val_t;
    typedef logic [LETTER_W-1:0] letter_t;

    localparam letter_t NO_LETTER = 8'h00;

    localparam val_t RN_VALUE [TABLE_LEN] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40,   12'd10,  12'd9,   12'd5,   12'd4,   12'd1
    };
    localparam letter_t RN_FIRST [TABLE_LEN] = '{
        8'h4D, 8'h43, 8'h44, 8'h43, 8'h43, 8'h58, 8'h4C,
        8'h58, 8'h58, 8'h49, 8'h56, 8'h49, 8'h49
    };
    localparam letter_t RN_SECOND [TABLE_LEN] = '{
        NO_LETTER, 8'h4D, NO_LETTER, 8'h44, NO_LETTER, 8'h43, NO_LETTER,
        8'h4C,     NO_LETTER, 8'h58, NO_LETTER, 8'h56, NO_LETTER
    };

    // Result status codes
    typedef enum logic [1:0] {
        ST_LETTER = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture a new number
        logic emit;   // produce one result beat
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a beat this cycle
        logic run_done;   // the beat being produced closes the run
    } stat_t;

    // First table entry not larger than the value; the ones entry as fallback
    function automatic idx_t rn_pick(input val_t rem);
        idx_t idx;
        idx = idx_t'(TABLE_LEN - 1);
        for (int i = TABLE_LEN - 1; i >= 0; i--) begin
            if (RN_VALUE[i] <= rem) begin
                idx = idx_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/core/rne_datapath.sv =====
`timescale 1ns / 1ps

module rne_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rne_pkg::cmd_t                      cmd,
    output rne_pkg::stat_t                     stat,
    input  logic signed [rne_pkg::NUM_W-1:0]   number_in,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [rne_pkg::LETTER_W-1:0]       letter,
    output logic [1:0]                         status,
    output logic                               last
);

    // Run state
    rne_pkg::val_t    rem_reg, rem_next;
    logic             sec_pend_reg, sec_pend_next;
    rne_pkg::letter_t sec_letter_reg, sec_letter_next;
    rne_pkg::status_t kind_reg, kind_next;

    // Output beat register
    logic             out_valid_reg, out_valid_next;
    rne_pkg::letter_t letter_reg, letter_next;
    rne_pkg::status_t status_reg, status_next;
    logic             last_reg, last_next;

    // Table lookup for the current remainder
    rne_pkg::idx_t    idx;
    rne_pkg::val_t    rem_sub;
    rne_pkg::letter_t second;

    assign idx     = rne_pkg::rn_pick(rem_reg);
    assign rem_sub = rem_reg - rne_pkg::RN_VALUE[idx];
    assign second  = rne_pkg::RN_SECOND[idx];

    // Next beat, from run state only
    always_comb
    begin
        if (kind_reg != rne_pkg::ST_LETTER) begin
            // zero or out of range: one flagged beat, no letter
            letter_next = rne_pkg::NO_LETTER;
            status_next = kind_reg;
            last_next   = 1'b1;
        end else if (sec_pend_reg) begin
            letter_next = sec_letter_reg;
            status_next = rne_pkg::ST_LETTER;
            last_next   = (rem_reg == '0);
        end else begin
            letter_next = rne_pkg::RN_FIRST[idx];
            status_next = rne_pkg::ST_LETTER;
            last_next   = (second == rne_pkg::NO_LETTER) && (rem_sub == '0);
        end
    end

    // Run bookkeeping
    always_comb
    begin
        rem_next        = rem_reg;
        sec_pend_next   = sec_pend_reg;
        sec_letter_next = sec_letter_reg;
        kind_next       = kind_reg;

        if (cmd.load) begin
            rem_next        = number_in[rne_pkg::VAL_W-1:0];
            sec_pend_next   = 1'b0;
            sec_letter_next = rne_pkg::NO_LETTER;
            if (number_in[rne_pkg::NUM_W-1] ||
                number_in[rne_pkg::VAL_W-1:0] >= rne_pkg::RN_LIMIT) begin
                kind_next = rne_pkg::ST_RANGE;
            end else if (number_in[rne_pkg::VAL_W-1:0] == '0) begin
                kind_next = rne_pkg::ST_EMPTY;
            end else begin
                kind_next = rne_pkg::ST_LETTER;
            end
        end

        if (cmd.emit && !cmd.load) begin
            if (kind_reg == rne_pkg::ST_LETTER) begin
                if (sec_pend_reg) begin
                    sec_pend_next = 1'b0;
                end else begin
                    rem_next        = rem_sub;
                    sec_pend_next   = (second != rne_pkg::NO_LETTER);
                    sec_letter_next = second;
                end
            end
        end
    end

    // Output valid: set on a new beat, cleared once taken
    always_comb
    begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            kind_reg      <= rne_pkg::ST_LETTER;
            rem_reg       <= '0;
            sec_pend_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            rem_reg       <= rem_next;
            sec_pend_reg  <= sec_pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sec_letter_reg <= sec_letter_next;
        if (cmd.emit) begin
            letter_reg <= letter_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.run_done = last_next;

    assign out_valid = out_valid_reg;
    assign letter    = letter_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/core/rne_ctrl.sv =====
`timescale 1ns / 1ps

module rne_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rne_pkg::stat_t  stat,
    output rne_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Sequencing: take a number in idle, then one beat per free output slot
    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.run_done) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/core/roman_numeral_encoder.sv =====
`timescale 1ns / 1ps

// Roman numeral encoder.
// Input channel: number_in (13-bit signed) with in_valid / in_stall. A beat is
// taken on a clock edge with in_valid high and in_stall low.
// Output channel: letter (ASCII), status and last with out_valid / out_stall.
// One input gives a run of letter beats, last set on the final one. Zero
// gives one beat with status empty; negative or 4000 and above gives one
// beat with status out of range; both with letter 0 and last set.
// The first beat enters the output register from the run state after the load.
// Throughput: one result beat per cycle from the greedy table step while the
// output is not stalled; the number itself is taken in the idle state first.
// in_stall is high from the cycle after a number is taken until the cycle
// after its last beat is loaded into the output register.
// A stall on the output freezes the run; the waiting beat holds steady.
// Reset (rst_n low, asynchronous) empties the output register and returns
// the block to idle, ready for a number.
module roman_numeral_encoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [rne_pkg::NUM_W-1:0]  number_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rne_pkg::LETTER_W-1:0]      letter,
    output logic [1:0]                        status,
    output logic                              last
);

    rne_pkg::cmd_t  cmd;
    rne_pkg::stat_t stat;

    rne_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    rne_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .number_in (number_in),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .letter    (letter),
        .status    (status),
        .last      (last)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef logic signed [rne_pkg::NUM_W-1:0] number_t;

    // One output beat as it should appear on the result channel
    typedef struct packed {
        rne_pkg::letter_t letter;
        rne_pkg::status_t status;
        logic             last;
    } numeral_beat_t;

    // Works out the letter beats of each accepted number and checks them in order
    class numeral_board;
        numeral_beat_t letters_due [$];
        int            errors;
        int            step_value [13];
        string         step_glyph [13];

        function new();
            errors     = 0;
            step_value = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
            step_glyph = '{"M", "CM", "D", "CD", "C", "XC", "L", "XL", "X", "IX",
                           "V", "IV", "I"};
        endfunction

        // Greedy expansion of one accepted number into its expected beats
        function void note_number(number_t num);
            int            value;
            int            rest;
            string         glyphs;
            numeral_beat_t b;
            value  = num;
            glyphs = "";
            if (value < 0 || value >= 4000) begin
                b = '{letter: rne_pkg::NO_LETTER, status: rne_pkg::ST_RANGE, last: 1'b1};
                letters_due.push_back(b);
            end
            else if (value == 0) begin
                b = '{letter: rne_pkg::NO_LETTER, status: rne_pkg::ST_EMPTY, last: 1'b1};
                letters_due.push_back(b);
            end
            else begin
                rest = value;
                for (int i = 0; i < 13; i++) begin
                    while (rest >= step_value[i]) begin
                        glyphs = {glyphs, step_glyph[i]};
                        rest   = rest - step_value[i];
                    end
                end
                for (int k = 0; k < glyphs.len(); k++) begin
                    b.letter = rne_pkg::letter_t'(glyphs[k]);
                    b.status = rne_pkg::ST_LETTER;
                    b.last   = (k == glyphs.len() - 1);
                    letters_due.push_back(b);
                end
            end
        endfunction

        // Compare one accepted result beat with the oldest expectation
        function void check_beat(rne_pkg::letter_t got_letter, logic [1:0] got_status,
                                 logic got_last);
            numeral_beat_t want;
            if (letters_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual letter %h status %0d last %0b",
                         $time, got_letter, got_status, got_last);
                return;
            end
            want = letters_due.pop_front();
            if (got_letter !== want.letter) begin
                errors++;
                $display("%0t: letter expected %h actual %h",
                         $time, want.letter, got_letter);
            end
            if (got_status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got_status);
            end
            if (got_last !== want.last) begin
                errors++;
                $display("%0t: last expected %0b actual %0b",
                         $time, want.last, got_last);
            end
        endfunction

        function int outstanding();
            return letters_due.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    number_t          number_in;
    logic             out_valid;
    logic             out_stall;
    rne_pkg::letter_t letter;
    logic [1:0]       status;
    logic             last;

    bit           idling;
    numeral_board board;

    roman_numeral_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .number_in (number_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .letter    (letter),
        .status    (status),
        .last      (last)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Random back-pressure on the result side
    always @(posedge clk)
    begin
        out_stall <= idling ? ($urandom_range(99) < 16) : 1'b0;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            board.check_beat(letter, status, last);
    end

    // Offer one number and hold it until the block takes the beat
    task automatic send_number(number_t num);
        in_valid  <= 1'b1;
        number_in <= num;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        board.note_number(num);
    endtask

    // Occasional gap between beats, long enough to land on any phase of a run
    task automatic maybe_gap();
        if (idling && $urandom_range(99) < 16) begin
            in_valid  <= 1'b0;
            number_in <= number_t'($urandom);
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Mostly valid numbers, with zero and raw 13-bit noise mixed in
    function automatic number_t pick_number();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        else if (roll < 20)
            return number_t'($urandom);
        else
            return number_t'($urandom_range(1, 3999));
    endfunction

    task automatic random_run(int count);
        for (int i = 0; i < count; i++) begin
            send_number(pick_number());
            maybe_gap();
        end
    endtask

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int corner_nums [25] = '{0, 1, 3999, 4000, 4095, -1, -4096, 3888, 4, 9, 40, 90,
                                 400, 900, 5, 50, 500, 1000, 14, 1994, 2421, 3, 444,
                                 999, -2};
        board     = new();
        idling    = 1'b1;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        number_in <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners: range edges, every subtractive pair, longest numeral
        foreach (corner_nums[i]) begin
            send_number(number_t'(corner_nums[i]));
            maybe_gap();
        end

        random_run(80);

        // Let the block drain completely before carrying on
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        @(posedge clk);

        // Back-to-back stretch, neither side holding off
        idling = 1'b0;
        random_run(50);
        idling = 1'b1;
        random_run(70);

        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
